>>> hdl/dhtc_pkg.sv
// Shared types, widths and constants for the heated dryer controller.
// No dependencies; imported by dryer_heater_timer_controller.
package dhtc_pkg;

  localparam int unsigned TEMP_W   = 7;
  localparam int unsigned MIN_W    = 10;
  localparam int unsigned STEP_W   = 8;
  localparam int unsigned SENSE_W  = 8;
  localparam int unsigned DUTY_W   = 16;
  localparam int unsigned SEC_W    = 16;
  localparam int unsigned CFG_IX_W = 3;
  localparam int unsigned CFG_D_W  = 10;

  localparam logic [DUTY_W-1:0] DUTY_FULL    = 16'hFFFF;
  localparam logic [DUTY_W-1:0] DUTY_PER_DEG = 16'd6553;
  localparam logic [6:0]        SEC_PER_MIN  = 7'd60;
  localparam logic [MIN_W:0]    MINUTES_TOP  = 11'd1023;
  localparam logic [9:0]        FULL_ERR     = 10'sd10;

  // Reset values of the configuration registers.
  localparam logic [TEMP_W-1:0] MIN_TEMP_RST     = 7'd30;
  localparam logic [TEMP_W-1:0] MAX_TEMP_RST     = 7'd70;
  localparam logic [TEMP_W-1:0] DEF_TEMP_RST     = 7'd50;
  localparam logic [MIN_W-1:0]  MIN_MINUTES_RST  = 10'd30;
  localparam logic [MIN_W-1:0]  MAX_MINUTES_RST  = 10'd720;
  localparam logic [MIN_W-1:0]  DEF_MINUTES_RST  = 10'd240;
  localparam logic [STEP_W-1:0] MINUTES_STEP_RST = 8'd30;
  localparam logic [TEMP_W-1:0] SAFETY_TEMP_RST  = 7'd85;

  typedef enum logic [1:0] {
    OP_BUTTONS = 2'd0,
    OP_TEMPS   = 2'd1,
    OP_TICK    = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } button_e;

  typedef enum logic [CFG_IX_W-1:0] {
    CFG_MIN_TEMP     = 3'd0,
    CFG_MAX_TEMP     = 3'd1,
    CFG_DEF_TEMP     = 3'd2,
    CFG_MIN_MINUTES  = 3'd3,
    CFG_MAX_MINUTES  = 3'd4,
    CFG_DEF_MINUTES  = 3'd5,
    CFG_MINUTES_STEP = 3'd6,
    CFG_SAFETY_TEMP  = 3'd7
  } cfg_index_e;

  // Run state and menu screen are kept one-hot and encoded at the outputs.
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_RUN   = 3'b010,
    MODE_PAUSE = 3'b100
  } mode_e;

  typedef enum logic [2:0] {
    SCR_MAIN = 3'b001,
    SCR_TEMP = 3'b010,
    SCR_TIME = 3'b100
  } screen_e;

  localparam logic [1:0] MODE_CODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_CODE_RUN   = 2'd1;
  localparam logic [1:0] MODE_CODE_PAUSE = 2'd2;
  localparam logic [1:0] SCR_CODE_MAIN   = 2'd0;
  localparam logic [1:0] SCR_CODE_TEMP   = 2'd1;
  localparam logic [1:0] SCR_CODE_TIME   = 2'd2;

  function automatic logic [1:0] mode_code(mode_e m);
    logic [1:0] c;
    case (m)
      MODE_RUN:   c = MODE_CODE_RUN;
      MODE_PAUSE: c = MODE_CODE_PAUSE;
      default:    c = MODE_CODE_IDLE;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] screen_code(screen_e s);
    logic [1:0] c;
    case (s)
      SCR_TEMP: c = SCR_CODE_TEMP;
      SCR_TIME: c = SCR_CODE_TIME;
      default:  c = SCR_CODE_MAIN;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/dryer_heater_timer_controller.sv
// Heated dryer controller: run state, menu editor, countdown and heater/fan drive.
// Depends on dhtc_pkg for widths, codes and constants.
//
//   channel   handshake                    payload
//   --------  ---------------------------  ----------------------------------------
//   input     in_valid_i / in_stall_o      opcode, buttons, air and heater temps
//   result    out_valid_o / out_stall_i    duties, lamp, mode, screen, settings
//   config    cfg_we_i                     cfg_index_i, cfg_wdata_i
//
// The next state and the drive are worked out in one pass from the state registers
// and the input, and land in the state registers and the result register at the
// same edge, so a new transaction is taken each cycle unless the input stalls.
// The path is set by the minutes editor (add, compare, select) followed by the
// multiply by sixty that loads the countdown.
// Reset restores the configuration defaults, idle mode, the main screen and the
// default settings. The input stalls only while a result is held and the output
// is stalled; otherwise the result register is refilled as it is emptied.
module dryer_heater_timer_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [dhtc_pkg::CFG_IX_W-1:0]  cfg_index_i,
  input  logic [dhtc_pkg::CFG_D_W-1:0]   cfg_wdata_i,
  // input transactions
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     opcode_i,
  input  logic [1:0]                     first_button_i,
  input  logic [1:0]                     second_button_i,
  input  logic signed [dhtc_pkg::SENSE_W-1:0] air_temp_i,
  input  logic signed [dhtc_pkg::SENSE_W-1:0] heater_temp_i,
  // result transactions
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [dhtc_pkg::DUTY_W-1:0]    heater_duty_o,
  output logic [dhtc_pkg::DUTY_W-1:0]    fan_duty_o,
  output logic                           lamp_o,
  output logic [1:0]                     run_mode_o,
  output logic [1:0]                     menu_screen_o,
  output logic [dhtc_pkg::TEMP_W-1:0]    target_temp_o,
  output logic [dhtc_pkg::MIN_W-1:0]     target_minutes_o,
  output logic [dhtc_pkg::TEMP_W-1:0]    edit_temp_o,
  output logic [dhtc_pkg::MIN_W-1:0]     edit_minutes_o,
  output logic [dhtc_pkg::SEC_W-1:0]     seconds_left_o,
  output logic                           step_down_o
);
  import dhtc_pkg::*;

  // Configuration registers.
  logic [TEMP_W-1:0] min_temp_q, max_temp_q, def_temp_q, safety_temp_q;
  logic [MIN_W-1:0]  min_minutes_q, max_minutes_q, def_minutes_q;
  logic [STEP_W-1:0] minutes_step_q;

  // Controller state.
  mode_e                    mode_q, mode_d;
  screen_e                  screen_q, screen_d;
  logic [TEMP_W-1:0]        target_temp_q, target_temp_d;
  logic [TEMP_W-1:0]        edit_temp_q, edit_temp_d;
  logic [MIN_W-1:0]         target_minutes_q, target_minutes_d;
  logic [MIN_W-1:0]         edit_minutes_q, edit_minutes_d;
  logic [SEC_W-1:0]         seconds_q, seconds_d;
  logic                     direction_q, direction_d;
  logic signed [SENSE_W-1:0] air_temp_q, air_temp_d;
  logic signed [SENSE_W-1:0] heater_temp_q, heater_temp_d;
  logic                     lamp_q, lamp_d;

  // Result register.
  logic                     out_valid_q;
  logic [DUTY_W-1:0]        heat_q, heat_d;
  logic [DUTY_W-1:0]        fan_q, fan_d;

  logic accept;
  logic load_seconds;
  logic signed [TEMP_W+1:0] temp_step;
  logic [MIN_W:0]           minutes_up;
  logic signed [SENSE_W+1:0] temp_err;
  logic signed [SENSE_W:0]   heater_ext;
  logic signed [SENSE_W:0]   safety_ext;

  // A transaction enters whenever the result register is empty or being drained.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_temp_q     <= MIN_TEMP_RST;
      max_temp_q     <= MAX_TEMP_RST;
      def_temp_q     <= DEF_TEMP_RST;
      min_minutes_q  <= MIN_MINUTES_RST;
      max_minutes_q  <= MAX_MINUTES_RST;
      def_minutes_q  <= DEF_MINUTES_RST;
      minutes_step_q <= MINUTES_STEP_RST;
      safety_temp_q  <= SAFETY_TEMP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MIN_TEMP:     min_temp_q     <= cfg_wdata_i[TEMP_W-1:0];
        CFG_MAX_TEMP:     max_temp_q     <= cfg_wdata_i[TEMP_W-1:0];
        CFG_DEF_TEMP:     def_temp_q     <= cfg_wdata_i[TEMP_W-1:0];
        CFG_MIN_MINUTES:  min_minutes_q  <= cfg_wdata_i[MIN_W-1:0];
        CFG_MAX_MINUTES:  max_minutes_q  <= cfg_wdata_i[MIN_W-1:0];
        CFG_DEF_MINUTES:  def_minutes_q  <= cfg_wdata_i[MIN_W-1:0];
        CFG_MINUTES_STEP: minutes_step_q <= cfg_wdata_i[STEP_W-1:0];
        CFG_SAFETY_TEMP:  safety_temp_q  <= cfg_wdata_i[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state: the two button events are applied in order, first then second,
  // each seeing what the other left, so these assignments are sequential.
  always_comb begin
    mode_d           = mode_q;
    screen_d         = screen_q;
    target_temp_d    = target_temp_q;
    edit_temp_d      = edit_temp_q;
    target_minutes_d = target_minutes_q;
    edit_minutes_d   = edit_minutes_q;
    seconds_d        = seconds_q;
    direction_d      = direction_q;
    air_temp_d       = air_temp_q;
    heater_temp_d    = heater_temp_q;
    lamp_d           = lamp_q;
    load_seconds     = 1'b0;
    temp_step        = '0;
    minutes_up       = '0;

    case (opcode_i)
      OP_BUTTONS: begin
        case (screen_q)
          SCR_MAIN: begin
            if (first_button_i == EV_SHORT) begin
              edit_temp_d = target_temp_q;
              screen_d    = SCR_TEMP;
            end
            if (second_button_i == EV_SHORT) begin
              case (mode_q)
                MODE_IDLE: begin
                  mode_d       = MODE_RUN;
                  load_seconds = 1'b1;
                end
                MODE_RUN: mode_d = MODE_PAUSE;
                default:  mode_d = MODE_RUN;
              endcase
            end
            if (second_button_i == EV_LONG) begin
              // Stop: back to idle with the default settings.
              mode_d           = MODE_IDLE;
              target_temp_d    = def_temp_q;
              target_minutes_d = def_minutes_q;
              seconds_d        = '0;
              lamp_d           = 1'b0;
            end
          end
          SCR_TEMP: begin
            if (first_button_i == EV_SHORT) begin
              // Step by one degree with wrap between the limits.
              if (direction_q) begin
                temp_step = $signed({2'b00, edit_temp_q}) - 9'sd1;
                if (temp_step < $signed({2'b00, min_temp_q})) begin
                  temp_step = $signed({2'b00, max_temp_q});
                end
              end else begin
                temp_step = $signed({2'b00, edit_temp_q}) + 9'sd1;
                if (temp_step > $signed({2'b00, max_temp_q})) begin
                  temp_step = $signed({2'b00, min_temp_q});
                end
              end
              edit_temp_d = temp_step[TEMP_W-1:0];
            end
            if (first_button_i == EV_LONG) direction_d = ~direction_d;
            if (second_button_i == EV_SHORT) begin
              target_temp_d  = edit_temp_d;
              edit_minutes_d = target_minutes_q;
              direction_d    = 1'b0;
              screen_d       = SCR_TIME;
            end
            if (second_button_i == EV_LONG) begin
              direction_d = 1'b0;
              screen_d    = SCR_MAIN;
            end
          end
          default: begin
            if (first_button_i == EV_SHORT) begin
              // Minutes wrap between the limits; running off either end of
              // the ten-bit range lands on the near limit instead.
              minutes_up = {1'b0, edit_minutes_q} + {3'b000, minutes_step_q};
              if (direction_q) begin
                if (edit_minutes_q <= min_minutes_q) begin
                  edit_minutes_d = max_minutes_q;
                end else if (edit_minutes_q < {2'b00, minutes_step_q}) begin
                  edit_minutes_d = min_minutes_q;
                end else begin
                  edit_minutes_d = edit_minutes_q - {2'b00, minutes_step_q};
                end
              end else begin
                if (edit_minutes_q >= max_minutes_q) begin
                  edit_minutes_d = min_minutes_q;
                end else if (minutes_up > MINUTES_TOP) begin
                  edit_minutes_d = max_minutes_q;
                end else begin
                  edit_minutes_d = minutes_up[MIN_W-1:0];
                end
              end
            end
            if (first_button_i == EV_LONG) direction_d = ~direction_d;
            if (second_button_i == EV_SHORT) begin
              target_minutes_d = edit_minutes_d;
              load_seconds     = 1'b1;
              mode_d           = MODE_RUN;
              direction_d      = 1'b0;
              screen_d         = SCR_MAIN;
            end
            if (second_button_i == EV_LONG) begin
              direction_d = 1'b0;
              screen_d    = SCR_MAIN;
            end
          end
        endcase
      end
      OP_TEMPS: begin
        air_temp_d    = air_temp_i;
        heater_temp_d = heater_temp_i;
      end
      OP_TICK: begin
        if (mode_q == MODE_RUN && seconds_q != '0) begin
          seconds_d = seconds_q - 1'b1;
          if (seconds_q == SEC_W'(1)) begin
            mode_d = MODE_IDLE;
            lamp_d = 1'b0;
          end
        end
      end
      default: ;
    endcase

    // A run start loads the countdown from the committed minutes.
    if (load_seconds) begin
      seconds_d = SEC_W'(target_minutes_d) * SEC_W'(SEC_PER_MIN);
    end

    // Heater and fan drive from the updated state.
    heat_d     = '0;
    fan_d      = '0;
    heater_ext = {heater_temp_d[SENSE_W-1], heater_temp_d};
    safety_ext = $signed({2'b00, safety_temp_q});
    temp_err   = $signed({3'b000, target_temp_d})
               - $signed({{2{air_temp_d[SENSE_W-1]}}, air_temp_d});
    if (mode_d != MODE_RUN) begin
      lamp_d = 1'b0;
    end else if (heater_ext > safety_ext) begin
      // Over-temperature cut-off: heater off, fan on, lamp unchanged.
      fan_d = DUTY_FULL;
    end else begin
      if (temp_err > $signed(FULL_ERR)) begin
        heat_d = DUTY_FULL;
      end else if (temp_err > 10'sd0) begin
        heat_d = DUTY_W'({12'd0, temp_err[3:0]} * DUTY_PER_DEG);
      end
      fan_d  = DUTY_FULL;
      lamp_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q           <= MODE_IDLE;
      screen_q         <= SCR_MAIN;
      target_temp_q    <= DEF_TEMP_RST;
      edit_temp_q      <= DEF_TEMP_RST;
      target_minutes_q <= DEF_MINUTES_RST;
      edit_minutes_q   <= DEF_MINUTES_RST;
      seconds_q        <= '0;
      direction_q      <= 1'b0;
      air_temp_q       <= '0;
      heater_temp_q    <= '0;
      lamp_q           <= 1'b0;
    end else if (accept) begin
      mode_q           <= mode_d;
      screen_q         <= screen_d;
      target_temp_q    <= target_temp_d;
      edit_temp_q      <= edit_temp_d;
      target_minutes_q <= target_minutes_d;
      edit_minutes_q   <= edit_minutes_d;
      seconds_q        <= seconds_d;
      direction_q      <= direction_d;
      air_temp_q       <= air_temp_d;
      heater_temp_q    <= heater_temp_d;
      lamp_q           <= lamp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Duties are the only result fields not already held in the state registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      heat_q <= heat_d;
      fan_q  <= fan_d;
    end
  end

  // The state registers change only on acceptance, which is also when the
  // result register loads, so they double as the held result payload.
  assign out_valid_o      = out_valid_q;
  assign heater_duty_o    = heat_q;
  assign fan_duty_o       = fan_q;
  assign lamp_o           = lamp_q;
  assign run_mode_o       = mode_code(mode_q);
  assign menu_screen_o    = screen_code(screen_q);
  assign target_temp_o    = target_temp_q;
  assign target_minutes_o = target_minutes_q;
  assign edit_temp_o      = edit_temp_q;
  assign edit_minutes_o   = edit_minutes_q;
  assign seconds_left_o   = seconds_q;
  assign step_down_o      = direction_q;

endmodule

>>> bench/dhtc_bench_pkg.sv
// Transaction records and the scoreboard for the heated dryer controller bench.
// The scoreboard predicts panel state and heater/fan drive and queues the results.
// Depends on dhtc_pkg for widths, codes, register indexes and constants.
package dhtc_bench_pkg;
  import dhtc_pkg::*;

  typedef struct {
    logic [1:0]                opcode;
    logic [1:0]                first_button;
    logic [1:0]                second_button;
    logic signed [SENSE_W-1:0] air_temp;
    logic signed [SENSE_W-1:0] heater_temp;
  } dryer_item_t;

  typedef struct {
    logic [DUTY_W-1:0] heater_duty;
    logic [DUTY_W-1:0] fan_duty;
    logic              lamp;
    logic [1:0]        run_mode;
    logic [1:0]        menu_screen;
    logic [TEMP_W-1:0] target_temp;
    logic [MIN_W-1:0]  target_minutes;
    logic [TEMP_W-1:0] edit_temp;
    logic [MIN_W-1:0]  edit_minutes;
    logic [SEC_W-1:0]  seconds_left;
    logic              step_down;
  } dryer_panel_t;

  class dryer_panel_board;
    int unsigned min_temp, max_temp, def_temp;
    int unsigned min_minutes, max_minutes, def_minutes;
    int unsigned minutes_step, safety_temp;

    logic [1:0]  mode;
    logic [1:0]  screen;
    int unsigned target_temp, edit_temp;
    int unsigned target_minutes, edit_minutes;
    int unsigned seconds;
    logic        step_down;
    logic        lamp;
    int          air_temp, heater_temp;

    dryer_panel_t expected_panel_q[$];
    int unsigned  mismatches;

    function new();
      min_temp       = MIN_TEMP_RST;
      max_temp       = MAX_TEMP_RST;
      def_temp       = DEF_TEMP_RST;
      min_minutes    = MIN_MINUTES_RST;
      max_minutes    = MAX_MINUTES_RST;
      def_minutes    = DEF_MINUTES_RST;
      minutes_step   = MINUTES_STEP_RST;
      safety_temp    = SAFETY_TEMP_RST;
      mode           = MODE_CODE_IDLE;
      screen         = SCR_CODE_MAIN;
      target_temp    = DEF_TEMP_RST;
      edit_temp      = DEF_TEMP_RST;
      target_minutes = DEF_MINUTES_RST;
      edit_minutes   = DEF_MINUTES_RST;
      seconds        = 0;
      step_down      = 1'b0;
      lamp           = 1'b0;
      air_temp       = 0;
      heater_temp    = 0;
      mismatches     = 0;
    endfunction

    function void write_reg(cfg_index_e ix, int unsigned value);
      case (ix)
        CFG_MIN_TEMP:     min_temp     = value & 32'h7F;
        CFG_MAX_TEMP:     max_temp     = value & 32'h7F;
        CFG_DEF_TEMP:     def_temp     = value & 32'h7F;
        CFG_MIN_MINUTES:  min_minutes  = value & 32'h3FF;
        CFG_MAX_MINUTES:  max_minutes  = value & 32'h3FF;
        CFG_DEF_MINUTES:  def_minutes  = value & 32'h3FF;
        CFG_MINUTES_STEP: minutes_step = value & 32'hFF;
        CFG_SAFETY_TEMP:  safety_temp  = value & 32'h7F;
        default: ;
      endcase
    endfunction

    // Button handling depends on the screen held before the transaction, even when
    // one of the two events moves to another screen.
    function void press_buttons(logic [1:0] first, logic [1:0] second);
      int          t;
      int unsigned m;
      case (screen)
        SCR_CODE_MAIN: begin
          if (first == EV_SHORT) begin
            edit_temp = target_temp;
            screen    = SCR_CODE_TEMP;
          end
          if (second == EV_SHORT) begin
            if (mode == MODE_CODE_IDLE) begin
              mode    = MODE_CODE_RUN;
              seconds = target_minutes * SEC_PER_MIN;
            end else if (mode == MODE_CODE_RUN) begin
              mode = MODE_CODE_PAUSE;
            end else begin
              mode = MODE_CODE_RUN;
            end
          end
          if (second == EV_LONG) begin
            mode           = MODE_CODE_IDLE;
            target_temp    = def_temp;
            target_minutes = def_minutes;
            seconds        = 0;
            lamp           = 1'b0;
          end
        end
        SCR_CODE_TEMP: begin
          if (first == EV_SHORT) begin
            t = int'(edit_temp);
            if (step_down) begin
              t = t - 1;
              if (t < int'(min_temp)) t = int'(max_temp);
            end else begin
              t = t + 1;
              if (t > int'(max_temp)) t = int'(min_temp);
            end
            edit_temp = unsigned'(t) & 32'h7F;
          end
          if (first == EV_LONG) step_down = ~step_down;
          if (second == EV_SHORT) begin
            target_temp  = edit_temp;
            edit_minutes = target_minutes;
            step_down    = 1'b0;
            screen       = SCR_CODE_TIME;
          end
          if (second == EV_LONG) begin
            step_down = 1'b0;
            screen    = SCR_CODE_MAIN;
          end
        end
        default: begin
          if (first == EV_SHORT) begin
            m = edit_minutes;
            if (step_down) begin
              if (m <= min_minutes) m = max_minutes;
              else if (m < minutes_step) m = min_minutes;
              else m = m - minutes_step;
            end else begin
              if (m >= max_minutes) m = min_minutes;
              else if (m + minutes_step > MINUTES_TOP) m = max_minutes;
              else m = m + minutes_step;
            end
            edit_minutes = m & 32'h3FF;
          end
          if (first == EV_LONG) step_down = ~step_down;
          if (second == EV_SHORT) begin
            target_minutes = edit_minutes;
            seconds        = target_minutes * SEC_PER_MIN;
            mode           = MODE_CODE_RUN;
            step_down      = 1'b0;
            screen         = SCR_CODE_MAIN;
          end
          if (second == EV_LONG) begin
            step_down = 1'b0;
            screen    = SCR_CODE_MAIN;
          end
        end
      endcase
    endfunction

    // Updates the state for one accepted input transaction and queues the result.
    function void note_input(dryer_item_t it);
      int           err;
      int unsigned  heat, fan;
      dryer_panel_t exp_panel;
      if (it.opcode == OP_BUTTONS) begin
        press_buttons(it.first_button, it.second_button);
      end else if (it.opcode == OP_TEMPS) begin
        air_temp    = it.air_temp;
        heater_temp = it.heater_temp;
      end else if (it.opcode == OP_TICK) begin
        if (mode == MODE_CODE_RUN && seconds > 0) begin
          seconds = seconds - 1;
          if (seconds == 0) begin
            mode = MODE_CODE_IDLE;
            lamp = 1'b0;
          end
        end
      end

      heat = 0;
      fan  = 0;
      if (mode != MODE_CODE_RUN) begin
        lamp = 1'b0;
      end else if (heater_temp > int'(safety_temp)) begin
        fan = DUTY_FULL;
      end else begin
        err = int'(target_temp) - air_temp;
        if (err > int'(FULL_ERR)) heat = DUTY_FULL;
        else if (err > 0) heat = unsigned'(err) * DUTY_PER_DEG;
        fan  = DUTY_FULL;
        lamp = 1'b1;
      end

      exp_panel.heater_duty    = DUTY_W'(heat);
      exp_panel.fan_duty       = DUTY_W'(fan);
      exp_panel.lamp           = lamp;
      exp_panel.run_mode       = mode;
      exp_panel.menu_screen    = screen;
      exp_panel.target_temp    = TEMP_W'(target_temp);
      exp_panel.target_minutes = MIN_W'(target_minutes);
      exp_panel.edit_temp      = TEMP_W'(edit_temp);
      exp_panel.edit_minutes   = MIN_W'(edit_minutes);
      exp_panel.seconds_left   = SEC_W'(seconds);
      exp_panel.step_down      = step_down;
      expected_panel_q.push_back(exp_panel);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned seen);
      if (want != seen) begin
        $error("%s: expected %0d, got %0d", field, want, seen);
        mismatches++;
      end
    endfunction

    function void check_result(dryer_panel_t got);
      dryer_panel_t want;
      if (expected_panel_q.size() == 0) begin
        $error("result transaction with no input transaction waiting for it");
        mismatches++;
        return;
      end
      want = expected_panel_q.pop_front();
      compare_field("heater_duty", want.heater_duty, got.heater_duty);
      compare_field("fan_duty", want.fan_duty, got.fan_duty);
      compare_field("lamp", want.lamp, got.lamp);
      compare_field("run_mode", want.run_mode, got.run_mode);
      compare_field("menu_screen", want.menu_screen, got.menu_screen);
      compare_field("target_temp", want.target_temp, got.target_temp);
      compare_field("target_minutes", want.target_minutes, got.target_minutes);
      compare_field("edit_temp", want.edit_temp, got.edit_temp);
      compare_field("edit_minutes", want.edit_minutes, got.edit_minutes);
      compare_field("seconds_left", want.seconds_left, got.seconds_left);
      compare_field("step_down", want.step_down, got.step_down);
    endfunction

    function int unsigned pending();
      return expected_panel_q.size();
    endfunction
  endclass

endpackage

>>> bench/dryer_heater_timer_controller_test.sv
// Top-level bench for the heated dryer controller: clock, reset, drivers, monitor.
// Depends on dhtc_pkg, dhtc_bench_pkg and the dryer_heater_timer_controller RTL.
module dryer_heater_timer_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dhtc_pkg::*;
  import dhtc_bench_pkg::*;

  localparam int unsigned CLK_PERIOD_NS   = 20;
  localparam int unsigned RESET_CYCLES    = 3;
  // A cycle counts as quiet when neither channel moves a transaction. The slowest
  // correct stretch is a settings load or a sender gap under heavy stall, so this
  // limit leaves a wide margin.
  localparam int unsigned QUIET_LIMIT     = 5000;
  localparam int unsigned ITEMS_PER_PHASE = 105;
  // The block presents a result in the cycle after it takes a transaction; the
  // tail is ample to catch a stray extra result.
  localparam int unsigned TAIL_CYCLES     = 4;

  // Codes outside the defined sets; the block must treat them as no-ops.
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [1:0] EV_SPARE = 2'd3;

  typedef struct {
    int unsigned min_temp;
    int unsigned max_temp;
    int unsigned def_temp;
    int unsigned min_minutes;
    int unsigned max_minutes;
    int unsigned def_minutes;
    int unsigned minutes_step;
    int unsigned safety_temp;
  } dryer_settings_t;

  logic                      clk_i           = 1'b0;
  logic                      rst_ni          = 1'b0;
  logic                      cfg_we_i        = 1'b0;
  logic [CFG_IX_W-1:0]       cfg_index_i     = '0;
  logic [CFG_D_W-1:0]        cfg_wdata_i     = '0;
  logic                      in_valid_i      = 1'b0;
  logic                      in_stall_o;
  logic [1:0]                opcode_i        = '0;
  logic [1:0]                first_button_i  = '0;
  logic [1:0]                second_button_i = '0;
  logic signed [SENSE_W-1:0] air_temp_i      = '0;
  logic signed [SENSE_W-1:0] heater_temp_i   = '0;
  logic                      out_valid_o;
  logic                      out_stall_i     = 1'b0;
  logic [DUTY_W-1:0]         heater_duty_o;
  logic [DUTY_W-1:0]         fan_duty_o;
  logic                      lamp_o;
  logic [1:0]                run_mode_o;
  logic [1:0]                menu_screen_o;
  logic [TEMP_W-1:0]         target_temp_o;
  logic [MIN_W-1:0]          target_minutes_o;
  logic [TEMP_W-1:0]         edit_temp_o;
  logic [MIN_W-1:0]          edit_minutes_o;
  logic [SEC_W-1:0]          seconds_left_o;
  logic                      step_down_o;

  dryer_panel_board board = new();

  int unsigned quiet_cycles  = 0;
  int unsigned stall_segment = 0;
  int unsigned stall_pct     = 0;

  dryer_heater_timer_controller dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .first_button_i   (first_button_i),
    .second_button_i  (second_button_i),
    .air_temp_i       (air_temp_i),
    .heater_temp_i    (heater_temp_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .heater_duty_o    (heater_duty_o),
    .fan_duty_o       (fan_duty_o),
    .lamp_o           (lamp_o),
    .run_mode_o       (run_mode_o),
    .menu_screen_o    (menu_screen_o),
    .target_temp_o    (target_temp_o),
    .target_minutes_o (target_minutes_o),
    .edit_temp_o      (edit_temp_o),
    .edit_minutes_o   (edit_minutes_o),
    .seconds_left_o   (seconds_left_o),
    .step_down_o      (step_down_o)
  );

  always #(CLK_PERIOD_NS / 2) clk_i = ~clk_i;

  // The receiver stalls in segments of random length. Each segment draws its own
  // stall rate, so some stretches run with no stall at all and others stall most
  // of the time.
  always @(posedge clk_i) begin
    if (stall_segment == 0) begin
      stall_segment <= $urandom_range(16, 80);
      stall_pct     <= $urandom_range(2) * 35;
    end else begin
      stall_segment <= stall_segment - 1;
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Result monitor and watchdog. All signals are read in the active region right
  // after the edge, so they hold the values that the edge itself sampled.
  always @(posedge clk_i) begin : monitor
    dryer_panel_t seen;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen.heater_duty    = heater_duty_o;
        seen.fan_duty       = fan_duty_o;
        seen.lamp           = lamp_o;
        seen.run_mode       = run_mode_o;
        seen.menu_screen    = menu_screen_o;
        seen.target_temp    = target_temp_o;
        seen.target_minutes = target_minutes_o;
        seen.edit_temp      = edit_temp_o;
        seen.edit_minutes   = edit_minutes_o;
        seen.seconds_left   = seconds_left_o;
        seen.step_down      = step_down_o;
        board.check_result(seen);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("dryer_heater_timer_controller verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Presents one transaction and holds it until the block takes it. The caller is
  // always at a rising edge, and valid stays high on return so that the next call
  // can follow back to back.
  task automatic send_item(input dryer_item_t it);
    in_valid_i      <= 1'b1;
    opcode_i        <= it.opcode;
    first_button_i  <= it.first_button;
    second_button_i <= it.second_button;
    air_temp_i      <= it.air_temp;
    heater_temp_i   <= it.heater_temp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_input(it);
  endtask

  task automatic send_fields(input logic [1:0] op, input logic [1:0] first,
                             input logic [1:0] second, input int air, input int heater);
    dryer_item_t it;
    it.opcode        = op;
    it.first_button  = first;
    it.second_button = second;
    it.air_temp      = SENSE_W'(air);
    it.heater_temp   = SENSE_W'(heater);
    send_item(it);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Holds the sender off until every expected result has come back, then waits out
  // the tail in which a stray extra result would show.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_setting(input cfg_index_e ix, input int unsigned value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= ix;
    cfg_wdata_i <= CFG_D_W'(value);
    @(posedge clk_i);
    board.write_reg(ix, value);
  endtask

  // Writes all eight registers on consecutive edges; only called while idle.
  task automatic load_settings(input dryer_settings_t s);
    write_setting(CFG_MIN_TEMP, s.min_temp);
    write_setting(CFG_MAX_TEMP, s.max_temp);
    write_setting(CFG_DEF_TEMP, s.def_temp);
    write_setting(CFG_MIN_MINUTES, s.min_minutes);
    write_setting(CFG_MAX_MINUTES, s.max_minutes);
    write_setting(CFG_DEF_MINUTES, s.def_minutes);
    write_setting(CFG_MINUTES_STEP, s.minutes_step);
    write_setting(CFG_SAFETY_TEMP, s.safety_temp);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Short presses dominate so that the menus are walked deeply; long presses are
  // kept rarer since a long press on the main screen stops the run.
  function automatic logic [1:0] random_press();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 45) return EV_SHORT;
    if (p < 57) return EV_LONG;
    if (p < 95) return EV_NONE;
    return EV_SPARE;
  endfunction

  // Builds one random transaction. Fields that the opcode ignores are random too.
  // Air readings mostly sit near the target so that every part of the
  // proportional band is hit; heater readings cluster around the cut-off.
  function automatic dryer_item_t random_item();
    dryer_item_t it;
    int unsigned p;
    int          v;
    it.first_button  = random_press();
    it.second_button = random_press();
    p = $urandom_range(99);
    if (p < 45) it.opcode = OP_BUTTONS;
    else if (p < 68) it.opcode = OP_TEMPS;
    else if (p < 96) it.opcode = OP_TICK;
    else it.opcode = OP_SPARE;

    if ($urandom_range(99) < 80) begin
      v = int'(board.target_temp) + int'($urandom_range(30)) - 15;
      if (v > 127) v = 127;
      it.air_temp = SENSE_W'(v);
    end else begin
      it.air_temp = SENSE_W'($urandom);
    end

    p = $urandom_range(99);
    if (p < 55) begin
      it.heater_temp = SENSE_W'($urandom_range(board.safety_temp));
    end else if (p < 85) begin
      v = int'(board.safety_temp) + int'($urandom_range(4)) - 2;
      if (v > 127) v = 127;
      it.heater_temp = SENSE_W'(v);
    end else begin
      it.heater_temp = SENSE_W'($urandom);
    end
    return it;
  endfunction

  // One phase: wait for idle, load a setting, then random traffic in bursts with
  // gaps. Halfway through, the sender holds off until all results are back.
  // Now and then a long train of ticks lets a short run count down to zero.
  task automatic run_phase(input dryer_settings_t s);
    int unsigned burst;
    int unsigned tick_run;
    dryer_item_t it;
    burst    = 0;
    tick_run = 0;
    drain_results();
    load_settings(s);
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      if (n == ITEMS_PER_PHASE / 2) drain_results();
      if (burst == 0) begin
        pause_sender($urandom_range(1, 6));
        burst = $urandom_range(1, 40);
      end
      burst--;
      it = random_item();
      if (tick_run > 0) begin
        it.opcode = OP_TICK;
        tick_run--;
      end else if (it.opcode == OP_TICK && $urandom_range(9) == 0) begin
        tick_run = $urandom_range(30, 90);
      end
      send_item(it);
    end
  endtask

  // Directed walk at the reset settings: unused codes, read errors, the whole
  // proportional band and the cut-off, pause and resume, both editors and stop.
  task automatic directed_walk();
    send_fields(OP_SPARE, EV_SPARE, EV_LONG, -1, 127);
    send_fields(OP_TEMPS, EV_SPARE, EV_SPARE, -1, -1);
    send_fields(OP_BUTTONS, EV_SPARE, EV_SPARE, 0, 0);
    send_fields(OP_BUTTONS, EV_NONE, EV_SHORT, 0, 0);     // start from idle
    send_fields(OP_TEMPS, EV_NONE, EV_NONE, 45, 20);      // five degrees short
    send_fields(OP_TEMPS, EV_NONE, EV_NONE, 40, 85);      // edge of full band, at cut-off
    send_fields(OP_TEMPS, EV_NONE, EV_NONE, 39, 86);      // just over cut-off
    send_fields(OP_TEMPS, EV_NONE, EV_NONE, 127, -128);   // far too hot air
    send_fields(OP_TEMPS, EV_NONE, EV_NONE, -128, 127);
    send_fields(OP_TEMPS, EV_NONE, EV_NONE, 50, 0);       // zero error
    send_fields(OP_TICK, EV_NONE, EV_NONE, 0, 0);
    send_fields(OP_BUTTONS, EV_NONE, EV_SHORT, 0, 0);     // pause
    send_fields(OP_TICK, EV_NONE, EV_NONE, 0, 0);         // no count while paused
    send_fields(OP_BUTTONS, EV_NONE, EV_SHORT, 0, 0);     // resume
    send_fields(OP_BUTTONS, EV_SHORT, EV_NONE, 0, 0);     // temperature editor
    send_fields(OP_BUTTONS, EV_LONG, EV_NONE, 0, 0);      // step down
    send_fields(OP_BUTTONS, EV_SHORT, EV_NONE, 0, 0);
    send_fields(OP_BUTTONS, EV_SHORT, EV_SHORT, 0, 0);    // step and commit
    send_fields(OP_BUTTONS, EV_SHORT, EV_NONE, 0, 0);     // time editor step
    send_fields(OP_BUTTONS, EV_LONG, EV_LONG, 0, 0);      // toggle, then leave
    send_fields(OP_BUTTONS, EV_SHORT, EV_SHORT, 0, 0);    // editor and pause at once
    send_fields(OP_BUTTONS, EV_NONE, EV_SHORT, 0, 0);
    send_fields(OP_BUTTONS, EV_NONE, EV_SHORT, 0, 0);     // start from time editor
    send_fields(OP_BUTTONS, EV_LONG, EV_LONG, 0, 0);      // stop restores defaults
    send_fields(OP_TICK, EV_NONE, EV_NONE, 0, 0);
  endtask

  initial begin : stimulus
    dryer_settings_t phases [$];
    dryer_settings_t s;

    // Field order: min/max/default temp, min/max/default minutes, step, cut-off.
    phases.push_back('{0, 100, 100, 0, 3, 1, 1, 100});
    phases.push_back('{0, 0, 0, 0, 0, 0, 1, 0});         // zero-length runs
    phases.push_back('{100, 100, 100, 1023, 1023, 1023, 255, 0});
    phases.push_back('{40, 60, 45, 0, 1023, 2, 255, 50}); // minutes overflow both ways
    phases.push_back('{70, 30, 50, 5, 2, 1, 3, 60});      // limits swapped
    s.min_temp     = $urandom_range(100);
    s.max_temp     = $urandom_range(100);
    s.def_temp     = $urandom_range(100);
    s.min_minutes  = $urandom_range(1023);
    s.max_minutes  = $urandom_range(1023);
    s.def_minutes  = $urandom_range(1023);
    s.minutes_step = $urandom_range(1, 255);
    s.safety_temp  = $urandom_range(100);
    phases.push_back(s);
    // Random limits again, with runs short enough to count out.
    s.min_minutes  = $urandom_range(2);
    s.max_minutes  = $urandom_range(1, 4);
    s.def_minutes  = $urandom_range(3);
    s.minutes_step = $urandom_range(1, 3);
    s.safety_temp  = $urandom_range(60, 100);
    phases.push_back(s);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed_walk();
    foreach (phases[i]) run_phase(phases[i]);
    drain_results();

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("dryer_heater_timer_controller verification clean");
    end else begin
      $display("dryer_heater_timer_controller verification failed");
    end
    $finish;
  end

endmodule
